### hdl/qapm_pkg.sv
package qapm_pkg;

    localparam int ANGLE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int LEVEL_W = 15;
    localparam int MOTOR_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // error = want + now, one bit of growth
    localparam int ERR_W    = ANGLE_W + 1;
    // floor(gain * err / 4096) and floor(gain * rate / 4096)
    localparam int P_TERM_W = ERR_W + GAIN_W - 12;
    localparam int D_TERM_W = ANGLE_W + GAIN_W - 12;
    localparam int AXIS_W   = P_TERM_W + 1;
    // base + throttle
    localparam int BT_W     = ANGLE_W + 1;
    localparam int MIX_W    = AXIS_W + 2;

    localparam logic [GAIN_W-1:0]  ROLL_P_RST  = 16'd3584;
    localparam logic [GAIN_W-1:0]  ROLL_D_RST  = 16'd64;
    localparam logic [GAIN_W-1:0]  PITCH_P_RST = 16'd3584;
    localparam logic [GAIN_W-1:0]  PITCH_D_RST = 16'd64;
    localparam logic [GAIN_W-1:0]  YAW_P_RST   = 16'd5120;
    localparam logic [GAIN_W-1:0]  YAW_D_RST   = 16'd256;
    localparam logic [LEVEL_W-1:0] LAUNCH_RST  = 15'd100;
    localparam logic [LEVEL_W-1:0] BASE_RST    = 15'd0;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic        [GAIN_W-1:0]  t_gain;
    typedef logic        [LEVEL_W-1:0] t_level;
    typedef logic        [MOTOR_W-1:0] t_motor;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [AXIS_W-1:0]  t_axis;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL_P  = 3'd0,
        CFG_ROLL_D  = 3'd1,
        CFG_PITCH_P = 3'd2,
        CFG_PITCH_D = 3'd3,
        CFG_YAW_P   = 3'd4,
        CFG_YAW_D   = 3'd5,
        CFG_LAUNCH  = 3'd6,
        CFG_BASE    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_axis_ctrl;

endpackage

### hdl/qapm_if.sv
interface qapm_in_if;
    import qapm_pkg::*;

    logic   valid;
    logic   ready;
    t_angle now_roll;
    t_angle now_pitch;
    t_angle want_roll;
    t_angle want_pitch;
    t_angle want_yaw;
    t_angle yaw_angle;
    t_angle rate_x;
    t_angle rate_y;
    t_angle rate_z;
    t_angle throttle_in;
    logic   armed;
    logic   link_ok;

    modport source (
        output valid, now_roll, now_pitch, want_roll, want_pitch, want_yaw,
               yaw_angle, rate_x, rate_y, rate_z, throttle_in, armed, link_ok,
        input  ready
    );
    modport sink (
        input  valid, now_roll, now_pitch, want_roll, want_pitch, want_yaw,
               yaw_angle, rate_x, rate_y, rate_z, throttle_in, armed, link_ok,
        output ready
    );
endinterface

interface qapm_out_if;
    import qapm_pkg::*;

    logic   valid;
    logic   ready;
    t_motor motor_front_left;
    t_motor motor_rear_left;
    t_motor motor_rear_right;
    t_motor motor_front_right;
    logic   driving;

    modport source (
        output valid, motor_front_left, motor_rear_left, motor_rear_right,
               motor_front_right, driving,
        input  ready
    );
    modport sink (
        input  valid, motor_front_left, motor_rear_left, motor_rear_right,
               motor_front_right, driving,
        output ready
    );
endinterface

### hdl/qapm_axis.sv
module qapm_axis (
    input  logic                  i_clk,
    input  qapm_pkg::t_axis_ctrl  i_ctrl,
    input  qapm_pkg::t_err        i_err,
    input  qapm_pkg::t_angle      i_rate,
    input  qapm_pkg::t_gain       i_p_gain,
    input  qapm_pkg::t_gain       i_d_gain,
    output qapm_pkg::t_axis       o_axis
);
    import qapm_pkg::*;

    logic signed [ERR_W+GAIN_W:0]    w_p_prod;
    logic signed [ANGLE_W+GAIN_W:0]  w_d_prod;
    logic signed [P_TERM_W-1:0]      r_p_term;
    logic signed [D_TERM_W-1:0]      r_d_term;
    t_axis                           r_axis;

    assign w_p_prod = i_err  * $signed({1'b0, i_p_gain});
    assign w_d_prod = i_rate * $signed({1'b0, i_d_gain});

    // dropping the low 12 bits of a signed product is floor division
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            r_p_term <= w_p_prod[ERR_W+GAIN_W-1:12];
            r_d_term <= w_d_prod[ANGLE_W+GAIN_W-1:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_axis <= AXIS_W'(r_p_term) + AXIS_W'(r_d_term);
        end
    end

    assign o_axis = r_axis;

endmodule

### hdl/quad_attitude_pd_motor_mixer.sv
// Channel  Dir  Handshake     Request
// i_in     in   valid/ready   one attitude sample, gyro rates, throttle, flags
// o_out    out  valid/ready   four motor commands and the driving flag
// i_cfg    in   write enable  gain, launch level or base offset register
//
// Four register stages: errors and gate, six multiplies, axis sums, mix and
// saturate into the output register. One request per cycle is sustained while
// the output is not stalled. Each stage holds its own valid bit and takes a new
// request whenever it is empty or its successor moves, so bubbles fill during an
// output stall. Reset clears the valid bits and loads the register defaults.
module quad_attitude_pd_motor_mixer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [qapm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [qapm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    qapm_in_if.sink                            i_in,
    qapm_out_if.source                         o_out
);
    import qapm_pkg::*;

    function automatic t_motor sat16(input logic signed [MIX_W-1:0] v);
        t_motor res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(MIX_W-MOTOR_W){1'b0}}, {MOTOR_W{1'b1}}})) begin
            res = '1;
        end else begin
            res = v[MOTOR_W-1:0];
        end
        return res;
    endfunction

    t_gain  r_roll_p, r_roll_d, r_pitch_p, r_pitch_d, r_yaw_p, r_yaw_d;
    t_level r_launch, r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_p  <= ROLL_P_RST;
            r_roll_d  <= ROLL_D_RST;
            r_pitch_p <= PITCH_P_RST;
            r_pitch_d <= PITCH_D_RST;
            r_yaw_p   <= YAW_P_RST;
            r_yaw_d   <= YAW_D_RST;
            r_launch  <= LAUNCH_RST;
            r_base    <= BASE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROLL_P:  r_roll_p  <= i_cfg_data;
                CFG_ROLL_D:  r_roll_d  <= i_cfg_data;
                CFG_PITCH_P: r_pitch_p <= i_cfg_data;
                CFG_PITCH_D: r_pitch_d <= i_cfg_data;
                CFG_YAW_P:   r_yaw_p   <= i_cfg_data;
                CFG_YAW_D:   r_yaw_d   <= i_cfg_data;
                CFG_LAUNCH:  r_launch  <= i_cfg_data[LEVEL_W-1:0];
                CFG_BASE:    r_base    <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables, back to front
    logic w_en1, w_en2, w_en3, w_en4;
    logic r1_vld, r2_vld, r3_vld, r4_vld;

    assign w_en4 = !r4_vld || o_out.ready;
    assign w_en3 = !r3_vld || w_en4;
    assign w_en2 = !r2_vld || w_en3;
    assign w_en1 = !r1_vld || w_en2;
    assign i_in.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w_en1) r1_vld <= i_in.valid;
            if (w_en2) r2_vld <= r1_vld;
            if (w_en3) r3_vld <= r2_vld;
            if (w_en4) r4_vld <= r3_vld;
        end
    end

    // stage 1: errors, base plus throttle, gate
    t_err   r1_roll_err, r1_pitch_err, r1_yaw_err;
    t_angle r1_rate_x, r1_rate_y, r1_rate_z;
    logic signed [BT_W-1:0] r1_bt, r2_bt, r3_bt;
    logic   r1_drive, r2_drive, r3_drive;
    logic   w_gate;

    assign w_gate = (i_in.throttle_in > $signed({1'b0, r_launch}))
                    && i_in.armed && i_in.link_ok;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_roll_err  <= ERR_W'(i_in.want_roll)  + ERR_W'(i_in.now_roll);
            r1_pitch_err <= ERR_W'(i_in.want_pitch) + ERR_W'(i_in.now_pitch);
            r1_yaw_err   <= ERR_W'(i_in.want_yaw)   + ERR_W'(i_in.yaw_angle);
            r1_rate_x    <= i_in.rate_x;
            r1_rate_y    <= i_in.rate_y;
            r1_rate_z    <= i_in.rate_z;
            r1_bt        <= $signed({{(BT_W-LEVEL_W){1'b0}}, r_base})
                            + BT_W'(i_in.throttle_in);
            r1_drive     <= w_gate;
        end
    end

    // stages 2 and 3 run inside the axis units; side data follows along
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_bt    <= r1_bt;
            r2_drive <= r1_drive;
        end
        if (w_en3) begin
            r3_bt    <= r2_bt;
            r3_drive <= r2_drive;
        end
    end

    t_axis_ctrl w_axis_ctrl;
    t_axis      w_roll, w_pitch, w_yaw;

    assign w_axis_ctrl.en_mul = w_en2;
    assign w_axis_ctrl.en_sum = w_en3;

    qapm_axis u_roll (
        .i_clk    (i_clk),
        .i_ctrl   (w_axis_ctrl),
        .i_err    (r1_roll_err),
        .i_rate   (r1_rate_y),
        .i_p_gain (r_roll_p),
        .i_d_gain (r_roll_d),
        .o_axis   (w_roll)
    );

    qapm_axis u_pitch (
        .i_clk    (i_clk),
        .i_ctrl   (w_axis_ctrl),
        .i_err    (r1_pitch_err),
        .i_rate   (r1_rate_x),
        .i_p_gain (r_pitch_p),
        .i_d_gain (r_pitch_d),
        .o_axis   (w_pitch)
    );

    qapm_axis u_yaw (
        .i_clk    (i_clk),
        .i_ctrl   (w_axis_ctrl),
        .i_err    (r1_yaw_err),
        .i_rate   (r1_rate_z),
        .i_p_gain (r_yaw_p),
        .i_d_gain (r_yaw_d),
        .o_axis   (w_yaw)
    );

    // stage 4: X-frame mix and saturation
    logic signed [MIX_W-1:0] w_b, w_r, w_p, w_y;
    logic signed [MIX_W-1:0] w_fl, w_rl, w_rr, w_fr;
    t_motor r4_fl, r4_rl, r4_rr, r4_fr;
    logic   r4_drive;

    assign w_b  = MIX_W'(r3_bt);
    assign w_r  = MIX_W'(w_roll);
    assign w_p  = MIX_W'(w_pitch);
    assign w_y  = MIX_W'(w_yaw);
    assign w_fl = w_b - w_r - w_p - w_y;
    assign w_rl = w_b - w_r + w_p + w_y;
    assign w_rr = w_b + w_r + w_p - w_y;
    assign w_fr = w_b + w_r - w_p + w_y;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_drive <= r3_drive;
            if (r3_drive) begin
                r4_fl <= sat16(w_fl);
                r4_rl <= sat16(w_rl);
                r4_rr <= sat16(w_rr);
                r4_fr <= sat16(w_fr);
            end else begin
                r4_fl <= '0;
                r4_rl <= '0;
                r4_rr <= '0;
                r4_fr <= '0;
            end
        end
    end

    assign o_out.valid             = r4_vld;
    assign o_out.motor_front_left  = r4_fl;
    assign o_out.motor_rear_left   = r4_rl;
    assign o_out.motor_rear_right  = r4_rr;
    assign o_out.motor_front_right = r4_fr;
    assign o_out.driving           = r4_drive;

endmodule

### verif/quad_attitude_pd_motor_mixer_test.sv
module quad_attitude_pd_motor_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qapm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int PIPE_LATENCY = 4;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int SHIFT_FRAC   = 12;
    localparam longint MOTOR_MAX = 65535;

    typedef struct {
        t_angle now_roll;
        t_angle now_pitch;
        t_angle want_roll;
        t_angle want_pitch;
        t_angle want_yaw;
        t_angle yaw_angle;
        t_angle rate_x;
        t_angle rate_y;
        t_angle rate_z;
        t_angle throttle_in;
        logic   armed;
        logic   link_ok;
    } t_sample;

    typedef struct packed {
        t_motor fl;
        t_motor rl;
        t_motor rr;
        t_motor fr;
        logic   driving;
    } t_motor_cmd;

    typedef struct {
        t_gain  roll_p;
        t_gain  roll_d;
        t_gain  pitch_p;
        t_gain  pitch_d;
        t_gain  yaw_p;
        t_gain  yaw_d;
        t_level launch;
        t_level base;
    } t_gains;

    class motor_mix_checker;
        t_gains     gains;
        t_motor_cmd expected_cmds[$];
        int         mismatches;
        int         strays;
        int         reported;
        int         checked;
        int         driving_seen;
        int         clipped;

        function new();
            gains = '{ROLL_P_RST, ROLL_D_RST, PITCH_P_RST, PITCH_D_RST,
                      YAW_P_RST, YAW_D_RST, LAUNCH_RST, BASE_RST};
            mismatches   = 0;
            strays       = 0;
            reported     = 0;
            checked      = 0;
            driving_seen = 0;
            clipped      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_ROLL_P:  gains.roll_p  = v;
                CFG_ROLL_D:  gains.roll_d  = v;
                CFG_PITCH_P: gains.pitch_p = v;
                CFG_PITCH_D: gains.pitch_d = v;
                CFG_YAW_P:   gains.yaw_p   = v;
                CFG_YAW_D:   gains.yaw_d   = v;
                CFG_LAUNCH:  gains.launch  = v[LEVEL_W-1:0];
                CFG_BASE:    gains.base    = v[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // each product floored on its own, then summed exactly
        function longint axis_out(t_gain p, t_gain d, longint err, longint rate);
            longint p_prod;
            longint d_prod;
            p_prod = longint'(p) * err;
            d_prod = longint'(d) * rate;
            return (p_prod >>> SHIFT_FRAC) + (d_prod >>> SHIFT_FRAC);
        endfunction

        function t_motor clamp(longint v);
            if (v < 0 || v > MOTOR_MAX)
                clipped++;
            if (v < 0)
                return '0;
            if (v > MOTOR_MAX)
                return '1;
            return t_motor'(v);
        endfunction

        function t_motor_cmd predict_motors(t_sample s);
            longint roll;
            longint pitch;
            longint yaw;
            longint thr;
            longint b;
            t_motor_cmd cmd;
            roll  = axis_out(gains.roll_p, gains.roll_d,
                             longint'(s.want_roll) + longint'(s.now_roll),
                             longint'(s.rate_y));
            pitch = axis_out(gains.pitch_p, gains.pitch_d,
                             longint'(s.want_pitch) + longint'(s.now_pitch),
                             longint'(s.rate_x));
            yaw   = axis_out(gains.yaw_p, gains.yaw_d,
                             longint'(s.want_yaw) + longint'(s.yaw_angle),
                             longint'(s.rate_z));
            thr   = longint'(s.throttle_in);
            cmd   = '0;
            // signed gate: negative throttle never drives
            if (thr > longint'(gains.launch) && s.armed === 1'b1 && s.link_ok === 1'b1) begin
                b = longint'(gains.base) + thr;
                cmd.fl = clamp(b - roll - pitch - yaw);
                cmd.rl = clamp(b - roll + pitch + yaw);
                cmd.rr = clamp(b + roll + pitch - yaw);
                cmd.fr = clamp(b + roll - pitch + yaw);
                cmd.driving = 1'b1;
            end
            return cmd;
        endfunction

        function void note_request(t_sample s);
            expected_cmds.push_back(predict_motors(s));
        endfunction

        function void check_result(t_motor_cmd got);
            t_motor_cmd want;
            if (got.driving === 1'b1)
                driving_seen++;
            if (expected_cmds.size() == 0) begin
                strays++;
                if (reported < REPORT_MAX)
                    $display("motor command with no request outstanding: fl=%0d rl=%0d rr=%0d fr=%0d drv=%b",
                             got.fl, got.rl, got.rr, got.fr, got.driving);
                reported++;
                return;
            end
            want = expected_cmds.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (reported < REPORT_MAX)
                    $display("command %0d: expected fl=%0d rl=%0d rr=%0d fr=%0d drv=%b, got fl=%0d rl=%0d rr=%0d fr=%0d drv=%b",
                             checked, want.fl, want.rl, want.rr, want.fr, want.driving,
                             got.fl, got.rl, got.rr, got.fr, got.driving);
                reported++;
            end
        endfunction

        function int failures();
            return mismatches + strays + expected_cmds.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qapm_in_if  samples_if ();
    qapm_out_if motors_if ();

    quad_attitude_pd_motor_mixer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (samples_if),
        .o_out      (motors_if)
    );

    motor_mix_checker motor_mix;
    bit idle_off;
    int cycles;
    int sent;
    int writes;
    int settings;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed out with %0d commands outstanding", motor_mix.expected_cmds.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && motors_if.valid === 1'b1 && motors_if.ready === 1'b1)
            motor_mix.check_result('{motors_if.motor_front_left, motors_if.motor_rear_left,
                                     motors_if.motor_rear_right, motors_if.motor_front_right,
                                     motors_if.driving});
    end

    // mostly short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        int hold;
        hold = 0;
        motors_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                motors_if.ready = 1'b0;
                hold--;
            end else if (idle_off || $urandom_range(0, 3) != 0) begin
                motors_if.ready = 1'b1;
            end else begin
                hold = pick_gap();
                motors_if.ready = (hold == 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    function automatic t_sample mk(int nr, int np, int wr, int wp, int wy, int ya,
                                   int rx, int ry, int rz, int thr, bit arm, bit lnk);
        t_sample s;
        s.now_roll    = t_angle'(nr);
        s.now_pitch   = t_angle'(np);
        s.want_roll   = t_angle'(wr);
        s.want_pitch  = t_angle'(wp);
        s.want_yaw    = t_angle'(wy);
        s.yaw_angle   = t_angle'(ya);
        s.rate_x      = t_angle'(rx);
        s.rate_y      = t_angle'(ry);
        s.rate_z      = t_angle'(rz);
        s.throttle_in = t_angle'(thr);
        s.armed       = arm;
        s.link_ok     = lnk;
        return s;
    endfunction

    function automatic t_angle rand_angle(bit wide);
        if (wide)
            return t_angle'($urandom);
        return t_angle'(int'($urandom_range(0, 1600)) - 800);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_reg(int unsigned lo, int unsigned hi);
        return CFG_DATA_W'($urandom_range(hi, lo));
    endfunction

    // mostly flyable samples: throttle above launch, armed, link up
    function automatic t_sample random_sample();
        t_sample s;
        bit wide;
        int lo;
        int hi;
        wide = ($urandom_range(0, 2) == 0);
        s.now_roll   = rand_angle(wide);
        s.now_pitch  = rand_angle(wide);
        s.want_roll  = rand_angle(wide);
        s.want_pitch = rand_angle(wide);
        s.want_yaw   = rand_angle(wide);
        s.yaw_angle  = rand_angle(wide);
        s.rate_x     = rand_angle(wide);
        s.rate_y     = rand_angle(wide);
        s.rate_z     = rand_angle(wide);
        lo = int'(motor_mix.gains.launch) + 1;
        hi = (lo + 20000 > 32767) ? 32767 : lo + 20000;
        if (lo <= 32767 && $urandom_range(0, 3) != 0)
            s.throttle_in = t_angle'($urandom_range(lo, hi));
        else
            s.throttle_in = t_angle'($urandom);
        if ($urandom_range(0, 6) != 0) begin
            s.armed   = 1'b1;
            s.link_ok = 1'b1;
        end else begin
            s.armed   = 1'($urandom_range(0, 1));
            s.link_ok = 1'($urandom_range(0, 1));
        end
        return s;
    endfunction

    task automatic send_sample(t_sample s);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            samples_if.valid = 1'b0;
        end
        @(negedge i_clk);
        samples_if.valid       = 1'b1;
        samples_if.now_roll    = s.now_roll;
        samples_if.now_pitch   = s.now_pitch;
        samples_if.want_roll   = s.want_roll;
        samples_if.want_pitch  = s.want_pitch;
        samples_if.want_yaw    = s.want_yaw;
        samples_if.yaw_angle   = s.yaw_angle;
        samples_if.rate_x      = s.rate_x;
        samples_if.rate_y      = s.rate_y;
        samples_if.rate_z      = s.rate_z;
        samples_if.throttle_in = s.throttle_in;
        samples_if.armed       = s.armed;
        samples_if.link_ok     = s.link_ok;
        do @(posedge i_clk); while (samples_if.ready !== 1'b1);
        motor_mix.note_request(s);
        sent++;
    endtask

    // drop valid and let the pipe empty before touching registers
    task automatic settle();
        @(negedge i_clk);
        samples_if.valid = 1'b0;
        while (motor_mix.expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        motor_mix.set_reg(idx, value);
        writes++;
    endtask

    task automatic load_regs(logic [CFG_DATA_W-1:0] rp, logic [CFG_DATA_W-1:0] rd,
                             logic [CFG_DATA_W-1:0] pp, logic [CFG_DATA_W-1:0] pd,
                             logic [CFG_DATA_W-1:0] yp, logic [CFG_DATA_W-1:0] yd,
                             logic [CFG_DATA_W-1:0] launch, logic [CFG_DATA_W-1:0] base);
        write_reg(CFG_ROLL_P, rp);
        write_reg(CFG_ROLL_D, rd);
        write_reg(CFG_PITCH_P, pp);
        write_reg(CFG_PITCH_D, pd);
        write_reg(CFG_YAW_P, yp);
        write_reg(CFG_YAW_D, yd);
        write_reg(CFG_LAUNCH, launch);
        write_reg(CFG_BASE, base);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        settings++;
    endtask

    task automatic run_phase(int n, bit quiet);
        idle_off = quiet;
        repeat (n) send_sample(random_sample());
        settle();
    endtask

    initial begin
        motor_mix  = new();
        idle_off   = 1'b0;
        sent       = 0;
        writes     = 0;
        settings   = 1;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ROLL_P;
        i_cfg_data = '0;
        samples_if.valid = 1'b0;
        samples_if.now_roll    = '0;
        samples_if.now_pitch   = '0;
        samples_if.want_roll   = '0;
        samples_if.want_pitch  = '0;
        samples_if.want_yaw    = '0;
        samples_if.yaw_angle   = '0;
        samples_if.rate_x      = '0;
        samples_if.rate_y      = '0;
        samples_if.rate_z      = '0;
        samples_if.throttle_in = '0;
        samples_if.armed       = 1'b0;
        samples_if.link_ok     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset gains: gate edges, flags, extremes, one axis at a time
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 101, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, -32768, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, -1, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 0, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 1, 0));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 0, 0));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                       32767, 1, 1));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, 32767, 1, 1));
        send_sample(mk(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                       -32768, 30000, 1, 1));
        send_sample(mk(0, 0, 16, 0, 0, 0, 0, 0, 0, 2000, 1, 1));
        send_sample(mk(0, -16, 0, 0, 0, 0, 0, 0, 0, 2000, 1, 1));
        send_sample(mk(0, 0, 0, 0, 16, 0, 0, 0, 0, 2000, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, -160, 0, 0, 2000, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 160, 0, 2000, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, -16, 2000, 1, 1));
        send_sample(mk(0, 0, 0, 0, 0, -32768, 0, 0, -32768, 32767, 1, 1));
        send_sample(mk(1234, -800, -1234, 800, 77, -77, 300, -300, 5, 5000, 1, 1));
        send_sample(mk('h5555, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa,
                       'h5555, 'haaaa, 'h5555, 'h5555, 1, 1));
        send_sample(mk(-3000, -3000, -3000, -3000, 0, 0, -2000, -2000, 0, 101, 1, 1));
        settle();

        // all gains zero, launch zero: motors follow throttle
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(80, 1'b0);
        // everything at full scale; launch masks to its top so nothing drives
        load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 16'hffff);
        run_phase(40, 1'b0);
        load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'd0, 16'h7fff);
        run_phase(60, 1'b1);
        load_regs(rand_reg(0, 1024), rand_reg(0, 1024),
                  rand_reg(0, 1024), rand_reg(0, 1024),
                  rand_reg(0, 1024), rand_reg(0, 1024),
                  rand_reg(0, 2000), rand_reg(0, 4000));
        run_phase(150, 1'b0);
        load_regs(rand_reg(0, 65535), rand_reg(0, 65535), rand_reg(0, 65535),
                  rand_reg(0, 65535), rand_reg(0, 65535), rand_reg(0, 65535),
                  rand_reg(0, 4000), rand_reg(0, 65535));
        run_phase(100, 1'b0);
        load_regs(rand_reg(0, 65535), rand_reg(0, 65535), rand_reg(0, 65535),
                  rand_reg(0, 65535), rand_reg(0, 65535), rand_reg(0, 65535),
                  rand_reg(0, 65535), rand_reg(0, 65535));
        run_phase(100, 1'b1);
        load_regs(ROLL_P_RST, ROLL_D_RST, PITCH_P_RST, PITCH_D_RST, YAW_P_RST, YAW_D_RST,
                  CFG_DATA_W'(LAUNCH_RST), CFG_DATA_W'(BASE_RST));
        run_phase(100, 1'b0);

        $display("%0d samples over %0d register settings (%0d writes)", sent, settings, writes);
        $display("%0d commands checked, %0d with motors driven, %0d motor values clipped",
                 motor_mix.checked, motor_mix.driving_seen, motor_mix.clipped);
        if (motor_mix.failures() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d stray commands, %0d missing", motor_mix.mismatches,
                     motor_mix.strays, motor_mix.expected_cmds.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
